>>> src/pbg_pkg.sv
// Shared constants and types for the prior box generator.
// No dependencies; used by prior_box_generator_core and its testbench.
package pbg_pkg;

	// Table depths
	localparam int MAX_SIZES  = 4;
	localparam int MAX_RATIOS = 4;
	localparam int SIDX_W = (MAX_SIZES > 1) ? $clog2(MAX_SIZES) : 1;
	localparam int RIDX_W = (MAX_RATIOS > 1) ? $clog2(MAX_RATIOS) : 1;
	localparam int SCNT_W = $clog2(MAX_SIZES + 1);
	localparam int RCNT_W = $clog2(MAX_RATIOS + 1);

	// Table word layouts: size {mean Q12.4, min}, ratio {inv root, root}
	localparam int SIZE_W  = 28;
	localparam int RATIO_W = 32;

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZES_USED    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATIOS_USED   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS    = 3'd7;

	// Mode flag bits
	localparam int FLAG_FLIP = 0;
	localparam int FLAG_CLIP = 1;
	localparam int FLAG_MAX  = 2;

	// Item kinds
	localparam logic [1:0] KIND_SIZE  = 2'd0;
	localparam logic [1:0] KIND_RATIO = 2'd1;
	localparam logic [1:0] KIND_CELL  = 2'd2;

	// Iteration counts and datapath widths
	localparam int SQRT_STEPS = 16;
	localparam int INV_STEPS  = 25;
	localparam int QUOT_W     = 18;
	localparam int MAG_W      = 36;
	localparam int POS_W      = 37;
	localparam int NUM_W      = 40;
	localparam int HALF_W     = 28;
	localparam int OUT_W      = 18;

	// Corner limits
	localparam logic [QUOT_W-1:0] SAT_POS = 18'd131071;
	localparam logic [QUOT_W-1:0] SAT_NEG = 18'd131072;
	localparam logic [QUOT_W-1:0] CLIP_HI = 18'd65536;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_ROOT,
		ST_INV,
		ST_INV_WR,
		ST_CENTER,
		ST_READ,
		ST_HALF,
		ST_POS,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_SQUARE,
		PH_MEAN,
		PH_RATIO,
		PH_FLIP
	} phase_t;

endpackage

>>> src/pbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/prior_box_generator_core.sv
// Prior box generator: size and ratio tables in RAM, per-box corner divider.
// Depends on pbg_pkg and pbg_ram.
// A size load runs the 16-step root; a ratio load runs the 16-step root, then the
// 25-step reciprocal divide. A cell emits its boxes in turn, each through the
// 18-step corner divider.
// One item at a time; results cannot be stalled. Reset clears control and
// configuration; table contents are undefined until loaded.
module prior_box_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_write,
	input  logic [pbg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pbg_pkg::CFG_W-1:0]         cfg_data,
	input  logic [1:0]                        kind,
	input  logic [1:0]                        entry_index,
	input  logic [11:0]                       min_box,
	input  logic [11:0]                       max_box,
	input  logic [11:0]                       ratio,
	input  logic [9:0]                        cell_row,
	input  logic [9:0]                        cell_col,
	output logic                              box_valid,
	output logic signed [pbg_pkg::OUT_W-1:0]  x_min,
	output logic signed [pbg_pkg::OUT_W-1:0]  y_min,
	output logic signed [pbg_pkg::OUT_W-1:0]  x_max,
	output logic signed [pbg_pkg::OUT_W-1:0]  y_max,
	output logic [5:0]                        box_number,
	output logic                              last_box
);

	// Configuration registers
	logic [7:0]  center_offset_q;
	logic [15:0] step_x_q, step_y_q;
	logic [12:0] image_width_q, image_height_q;
	logic [2:0]  sizes_used_q, ratios_used_q, mode_flags_q;

	// Control
	pbg_pkg::state_t state_q, state_d;
	pbg_pkg::phase_t phase_q, phase_n;
	logic [4:0]  cnt_q;
	logic        accept;
	logic        idx_ok;

	// Load path
	logic        is_ratio_q;
	logic [1:0]  idx_q;
	logic [11:0] min_q;
	logic [31:0] sq_rem_q, sq_root_q;
	logic [31:0] sq_bit;
	logic [32:0] sq_trial;
	logic [31:0] sq_rem_n, sq_root_n;
	logic [16:0] root_rnd;
	logic [15:0] iv_den_q;
	logic [15:0] iv_rem_q;
	logic [24:0] iv_num_q, iv_quot_q;
	logic [16:0] iv_t;
	logic [15:0] iv_rem_n;
	logic        iv_qbit;
	logic [15:0] inv_sat;

	// Cell path
	logic [9:0]  row_q, col_q;
	logic [17:0] cpos_x, cpos_y;
	logic [33:0] cprod_x, cprod_y;
	logic [pbg_pkg::MAG_W-1:0]  cx_q, cy_q;
	logic [pbg_pkg::HALF_W-1:0] hw_q, hh_q, hw_n, hh_n;
	logic [pbg_pkg::HALF_W-1:0] prod_w, prod_h;
	logic [pbg_pkg::SCNT_W-1:0] s_q, s_n, ns;
	logic [pbg_pkg::RCNT_W-1:0] r_q, r_n, nr;
	logic [5:0]  k_q;
	logic        done_n;
	logic        last_size, last_ratio;
	logic [12:0] div_w, div_h;

	// Divider lanes: x_min, y_min, x_max, y_max
	logic [12:0]               lane_div  [4];
	logic signed [pbg_pkg::POS_W-1:0] pos_c [4];
	logic [pbg_pkg::MAG_W-1:0] mag_c     [4];
	logic [pbg_pkg::NUM_W-1:0] num_c     [4];
	logic [12:0]               lane_rem_q  [4];
	logic [17:0]               lane_num_q  [4];
	logic [pbg_pkg::QUOT_W-1:0] lane_quot_q [4];
	logic [3:0]                lane_ovf_q, lane_neg_q;
	logic [13:0]               lane_t    [4];
	logic [12:0]               lane_rem_n [4];
	logic [3:0]                lane_qbit;
	logic [pbg_pkg::OUT_W-1:0] sat_c     [4];

	// Table memories
	logic                       size_we, ratio_we;
	logic [pbg_pkg::SIDX_W-1:0] size_waddr, size_raddr;
	logic [pbg_pkg::RIDX_W-1:0] ratio_waddr, ratio_raddr;
	logic [pbg_pkg::SIZE_W-1:0]  size_wdata, size_rdata;
	logic [pbg_pkg::RATIO_W-1:0] ratio_wdata, ratio_rdata;

	// Output registers
	logic        box_valid_q;
	logic [pbg_pkg::OUT_W-1:0] x_min_q, y_min_q, x_max_q, y_max_q;
	logic [5:0]  box_number_q;
	logic        last_box_q;

	pbg_ram #(.WIDTH(pbg_pkg::SIZE_W), .DEPTH(pbg_pkg::MAX_SIZES)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_waddr),
		.wdata (size_wdata),
		.raddr (size_raddr),
		.rdata (size_rdata)
	);

	pbg_ram #(.WIDTH(pbg_pkg::RATIO_W), .DEPTH(pbg_pkg::MAX_RATIOS)) u_ratio_ram (
		.clk   (clk),
		.we    (ratio_we),
		.waddr (ratio_waddr),
		.wdata (ratio_wdata),
		.raddr (ratio_raddr),
		.rdata (ratio_rdata)
	);

	assign accept = start && (state_q == pbg_pkg::ST_IDLE);
	assign idx_ok = (kind == pbg_pkg::KIND_SIZE) ?
		(int'(entry_index) < pbg_pkg::MAX_SIZES) :
		(int'(entry_index) < pbg_pkg::MAX_RATIOS);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_offset_q <= 8'd128;
			step_x_q        <= 16'd128;
			step_y_q        <= 16'd128;
			image_width_q   <= 13'd300;
			image_height_q  <= 13'd300;
			sizes_used_q    <= 3'd1;
			ratios_used_q   <= 3'd0;
			mode_flags_q    <= 3'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pbg_pkg::REG_CENTER_OFFSET: center_offset_q <= cfg_data[7:0];
				pbg_pkg::REG_STEP_X:        step_x_q        <= cfg_data;
				pbg_pkg::REG_STEP_Y:        step_y_q        <= cfg_data;
				pbg_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[12:0];
				pbg_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[12:0];
				pbg_pkg::REG_SIZES_USED:    sizes_used_q    <= cfg_data[2:0];
				pbg_pkg::REG_RATIOS_USED:   ratios_used_q   <= cfg_data[2:0];
				pbg_pkg::REG_MODE_FLAGS:    mode_flags_q    <= cfg_data[2:0];
			endcase
		end
	end

	// Clamp counts to the table depths; a zero image size acts as one
	always_comb begin
		ns = (int'(sizes_used_q) > pbg_pkg::MAX_SIZES) ?
			pbg_pkg::SCNT_W'(pbg_pkg::MAX_SIZES) : pbg_pkg::SCNT_W'(sizes_used_q);
		nr = (int'(ratios_used_q) > pbg_pkg::MAX_RATIOS) ?
			pbg_pkg::RCNT_W'(pbg_pkg::MAX_RATIOS) : pbg_pkg::RCNT_W'(ratios_used_q);
		div_w = (image_width_q == 13'd0) ? 13'd1 : image_width_q;
		div_h = (image_height_q == 13'd0) ? 13'd1 : image_height_q;
	end

	// Square root step, one result bit per cycle
	always_comb begin
		sq_bit   = 32'd1 << (5'd30 - {cnt_q[3:0], 1'b0});
		sq_trial = {1'b0, sq_root_q} + {1'b0, sq_bit};
		if ({1'b0, sq_rem_q} >= sq_trial) begin
			sq_rem_n  = sq_rem_q - sq_trial[31:0];
			sq_root_n = (sq_root_q >> 1) + sq_bit;
		end else begin
			sq_rem_n  = sq_rem_q;
			sq_root_n = sq_root_q >> 1;
		end
		// round to nearest: bump when remainder exceeds the root
		root_rnd = sq_root_q[16:0] + 17'((sq_rem_q > sq_root_q) ? 1 : 0);
	end

	// Reciprocal root step; a zero root yields all ones and saturates
	always_comb begin
		iv_t = {iv_rem_q, iv_num_q[24]};
		if (iv_t >= {1'b0, iv_den_q}) begin
			iv_rem_n = 16'(iv_t - {1'b0, iv_den_q});
			iv_qbit  = 1'b1;
		end else begin
			iv_rem_n = iv_t[15:0];
			iv_qbit  = 1'b0;
		end
		inv_sat = (iv_quot_q > 25'd65535) ? 16'hFFFF : iv_quot_q[15:0];
	end

	// Cell centers in 2^-13 pixel units
	always_comb begin
		cpos_x  = {col_q, 8'b0} + 18'(center_offset_q);
		cpos_y  = {row_q, 8'b0} + 18'(center_offset_q);
		cprod_x = cpos_x * step_x_q;
		cprod_y = cpos_y * step_y_q;
	end

	// Half extents of the current box
	always_comb begin
		prod_w = size_rdata[11:0] * ratio_rdata[15:0];
		prod_h = size_rdata[11:0] * ratio_rdata[31:16];
		unique case (phase_q)
			pbg_pkg::PH_SQUARE: begin
				hw_n = pbg_pkg::HALF_W'({size_rdata[11:0], 12'b0});
				hh_n = pbg_pkg::HALF_W'({size_rdata[11:0], 12'b0});
			end
			pbg_pkg::PH_MEAN: begin
				hw_n = pbg_pkg::HALF_W'({size_rdata[27:12], 8'b0});
				hh_n = pbg_pkg::HALF_W'({size_rdata[27:12], 8'b0});
			end
			pbg_pkg::PH_RATIO: begin
				hw_n = prod_w;
				hh_n = prod_h;
			end
			pbg_pkg::PH_FLIP: begin
				hw_n = prod_h;
				hh_n = prod_w;
			end
		endcase
	end

	// Corner positions, scaled numerators, divide steps and saturation
	always_comb begin
		pos_c[0] = $signed({1'b0, cx_q}) - $signed({9'b0, hw_q});
		pos_c[1] = $signed({1'b0, cy_q}) - $signed({9'b0, hh_q});
		pos_c[2] = $signed({1'b0, cx_q}) + $signed({9'b0, hw_q});
		pos_c[3] = $signed({1'b0, cy_q}) + $signed({9'b0, hh_q});
		for (int i = 0; i < 4; i++) begin
			lane_div[i] = (i % 2 == 1) ? div_h : div_w;
			mag_c[i] = pos_c[i][pbg_pkg::POS_W-1] ?
				pbg_pkg::MAG_W'(-pos_c[i]) : pbg_pkg::MAG_W'(pos_c[i]);
			num_c[i] = pbg_pkg::NUM_W'({mag_c[i], 3'b0}) +
				pbg_pkg::NUM_W'(lane_div[i] >> 1);
			lane_t[i] = {lane_rem_q[i], lane_num_q[i][17]};
			if (lane_t[i] >= {1'b0, lane_div[i]}) begin
				lane_rem_n[i] = 13'(lane_t[i] - {1'b0, lane_div[i]});
				lane_qbit[i]  = 1'b1;
			end else begin
				lane_rem_n[i] = lane_t[i][12:0];
				lane_qbit[i]  = 1'b0;
			end
			if (mode_flags_q[pbg_pkg::FLAG_CLIP]) begin
				if (lane_neg_q[i]) begin
					sat_c[i] = '0;
				end else if (lane_ovf_q[i] || lane_quot_q[i] > pbg_pkg::CLIP_HI) begin
					sat_c[i] = pbg_pkg::CLIP_HI;
				end else begin
					sat_c[i] = lane_quot_q[i];
				end
			end else if (lane_neg_q[i]) begin
				if (lane_ovf_q[i] || lane_quot_q[i] > pbg_pkg::SAT_NEG) begin
					sat_c[i] = pbg_pkg::SAT_NEG;
				end else begin
					sat_c[i] = 18'(19'd0 - {1'b0, lane_quot_q[i]});
				end
			end else if (lane_ovf_q[i] || lane_quot_q[i] > pbg_pkg::SAT_POS) begin
				sat_c[i] = pbg_pkg::SAT_POS;
			end else begin
				sat_c[i] = lane_quot_q[i];
			end
		end
	end

	// Box order per size: square, mean when the max flag is set, then each ratio with its flip when the flip flag is set
	always_comb begin
		last_size  = (int'(s_q) + 1) >= int'(ns);
		last_ratio = (int'(r_q) + 1) >= int'(nr);
		s_n     = s_q;
		r_n     = r_q;
		phase_n = phase_q;
		done_n  = 1'b0;
		unique case (phase_q)
			pbg_pkg::PH_SQUARE: begin
				if (mode_flags_q[pbg_pkg::FLAG_MAX]) begin
					phase_n = pbg_pkg::PH_MEAN;
				end else if (nr != '0) begin
					phase_n = pbg_pkg::PH_RATIO;
					r_n     = '0;
				end else begin
					phase_n = pbg_pkg::PH_SQUARE;
					s_n     = s_q + 1'b1;
					done_n  = last_size;
				end
			end
			pbg_pkg::PH_MEAN: begin
				if (nr != '0) begin
					phase_n = pbg_pkg::PH_RATIO;
					r_n     = '0;
				end else begin
					phase_n = pbg_pkg::PH_SQUARE;
					s_n     = s_q + 1'b1;
					done_n  = last_size;
				end
			end
			pbg_pkg::PH_RATIO: begin
				if (mode_flags_q[pbg_pkg::FLAG_FLIP]) begin
					phase_n = pbg_pkg::PH_FLIP;
				end else if (!last_ratio) begin
					r_n = r_q + 1'b1;
				end else begin
					phase_n = pbg_pkg::PH_SQUARE;
					s_n     = s_q + 1'b1;
					done_n  = last_size;
				end
			end
			pbg_pkg::PH_FLIP: begin
				if (!last_ratio) begin
					phase_n = pbg_pkg::PH_RATIO;
					r_n     = r_q + 1'b1;
				end else begin
					phase_n = pbg_pkg::PH_SQUARE;
					s_n     = s_q + 1'b1;
					done_n  = last_size;
				end
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbg_pkg::ST_IDLE: begin
				if (accept) begin
					if ((kind == pbg_pkg::KIND_SIZE || kind == pbg_pkg::KIND_RATIO)
							&& idx_ok) begin
						state_d = pbg_pkg::ST_SQRT;
					end else if (kind == pbg_pkg::KIND_CELL && ns != '0) begin
						state_d = pbg_pkg::ST_CENTER;
					end
				end
			end
			pbg_pkg::ST_SQRT:
				if (int'(cnt_q) == pbg_pkg::SQRT_STEPS - 1) state_d = pbg_pkg::ST_ROOT;
			pbg_pkg::ST_ROOT:
				state_d = is_ratio_q ? pbg_pkg::ST_INV : pbg_pkg::ST_IDLE;
			pbg_pkg::ST_INV:
				if (int'(cnt_q) == pbg_pkg::INV_STEPS - 1) state_d = pbg_pkg::ST_INV_WR;
			pbg_pkg::ST_INV_WR: state_d = pbg_pkg::ST_IDLE;
			pbg_pkg::ST_CENTER: state_d = pbg_pkg::ST_READ;
			pbg_pkg::ST_READ:   state_d = pbg_pkg::ST_HALF;
			pbg_pkg::ST_HALF:   state_d = pbg_pkg::ST_POS;
			pbg_pkg::ST_POS:    state_d = pbg_pkg::ST_DIV;
			pbg_pkg::ST_DIV:
				if (int'(cnt_q) == pbg_pkg::QUOT_W - 1) state_d = pbg_pkg::ST_EMIT;
			pbg_pkg::ST_EMIT:
				state_d = done_n ? pbg_pkg::ST_IDLE : pbg_pkg::ST_READ;
			default: state_d = pbg_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the controller: busy and table port controls
	always_comb begin
		busy        = (state_q != pbg_pkg::ST_IDLE);
		size_we     = (state_q == pbg_pkg::ST_ROOT) && !is_ratio_q;
		size_waddr  = pbg_pkg::SIDX_W'(idx_q);
		size_wdata  = {root_rnd[15:0], min_q};
		ratio_we    = (state_q == pbg_pkg::ST_INV_WR);
		ratio_waddr = pbg_pkg::RIDX_W'(idx_q);
		ratio_wdata = {inv_sat, iv_den_q};
		size_raddr  = pbg_pkg::SIDX_W'(s_q);
		ratio_raddr = pbg_pkg::RIDX_W'(r_q);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbg_pkg::ST_IDLE;
			cnt_q       <= '0;
			box_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			box_valid_q <= (state_q == pbg_pkg::ST_EMIT);
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pbg_pkg::ST_IDLE: begin
				is_ratio_q <= (kind == pbg_pkg::KIND_RATIO);
				idx_q      <= entry_index;
				min_q      <= min_box;
				row_q      <= cell_row;
				col_q      <= cell_col;
				sq_root_q  <= '0;
				sq_rem_q   <= (kind == pbg_pkg::KIND_RATIO) ?
					{4'b0, ratio, 16'b0} : {24'(min_box) * 24'(max_box), 8'b0};
			end
			pbg_pkg::ST_SQRT: begin
				sq_rem_q  <= sq_rem_n;
				sq_root_q <= sq_root_n;
			end
			pbg_pkg::ST_ROOT: begin
				// load the reciprocal divide: (2^24 + root/2) / root
				iv_den_q  <= root_rnd[15:0];
				iv_num_q  <= 25'h100_0000 + 25'(root_rnd[15:1]);
				iv_rem_q  <= '0;
				iv_quot_q <= '0;
			end
			pbg_pkg::ST_INV: begin
				iv_rem_q  <= iv_rem_n;
				iv_num_q  <= iv_num_q << 1;
				iv_quot_q <= {iv_quot_q[23:0], iv_qbit};
			end
			pbg_pkg::ST_INV_WR: begin
				iv_quot_q <= iv_quot_q;
			end
			pbg_pkg::ST_CENTER: begin
				cx_q    <= {1'b0, cprod_x, 1'b0};
				cy_q    <= {1'b0, cprod_y, 1'b0};
				s_q     <= '0;
				r_q     <= '0;
				phase_q <= pbg_pkg::PH_SQUARE;
				k_q     <= '0;
			end
			pbg_pkg::ST_READ: begin
				k_q <= k_q;
			end
			pbg_pkg::ST_HALF: begin
				hw_q <= hw_n;
				hh_q <= hh_n;
			end
			pbg_pkg::ST_POS: begin
				// overflow when the quotient cannot fit the corner width
				for (int i = 0; i < 4; i++) begin
					lane_rem_q[i]  <= 13'(num_c[i][pbg_pkg::NUM_W-1:pbg_pkg::QUOT_W]);
					lane_num_q[i]  <= num_c[i][pbg_pkg::QUOT_W-1:0];
					lane_quot_q[i] <= '0;
					lane_ovf_q[i]  <= num_c[i][pbg_pkg::NUM_W-1:pbg_pkg::QUOT_W]
						>= 22'(lane_div[i]);
					lane_neg_q[i]  <= pos_c[i][pbg_pkg::POS_W-1];
				end
			end
			pbg_pkg::ST_DIV: begin
				for (int i = 0; i < 4; i++) begin
					lane_rem_q[i]  <= lane_rem_n[i];
					lane_num_q[i]  <= lane_num_q[i] << 1;
					lane_quot_q[i] <= {lane_quot_q[i][pbg_pkg::QUOT_W-2:0], lane_qbit[i]};
				end
			end
			pbg_pkg::ST_EMIT: begin
				x_min_q      <= sat_c[0];
				y_min_q      <= sat_c[1];
				x_max_q      <= sat_c[2];
				y_max_q      <= sat_c[3];
				box_number_q <= k_q;
				last_box_q   <= done_n;
				k_q          <= k_q + 1'b1;
				s_q          <= s_n;
				r_q          <= r_n;
				phase_q      <= phase_n;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign box_valid  = box_valid_q;
	assign x_min      = $signed(x_min_q);
	assign y_min      = $signed(y_min_q);
	assign x_max      = $signed(x_max_q);
	assign y_max      = $signed(y_max_q);
	assign box_number = box_number_q;
	assign last_box   = last_box_q;

	// Divider never runs past its quotient width
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pbg_pkg::ST_DIV |-> int'(cnt_q) < pbg_pkg::QUOT_W)
		else $error("corner divider overran");

	// Beats never come back to back
	a_beat_gap: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |=> !box_valid)
		else $error("back-to-back result beats");

	// More boxes pending keeps the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !last_box |-> busy)
		else $error("idle before the last box");

	// Last box frees the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && last_box |-> !busy)
		else $error("busy after the last box");

endmodule

>>> tb/sv/prior_box_generator_core_tb.sv
// Self-checking testbench for prior_box_generator_core: loads size and ratio tables,
// generates cells and checks every emitted box against an in-bench fixed-point predictor.
// Depends on pbg_pkg and the prior_box_generator_core RTL.
module prior_box_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [pbg_pkg::OUT_W-1:0] x0, y0, x1, y1;
		logic [5:0]              num;
		logic                    last;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_write = 1'b0;
	logic [pbg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pbg_pkg::CFG_W-1:0] cfg_data = '0;
	logic [1:0] kind = '0;
	logic [1:0] entry_index = '0;
	logic [11:0] min_box = '0, max_box = '0, ratio = '0;
	logic [9:0] cell_row = '0, cell_col = '0;
	logic box_valid;
	logic signed [pbg_pkg::OUT_W-1:0] x_min, y_min, x_max, y_max;
	logic [5:0] box_number;
	logic last_box;

	prior_box_generator_core dut (.*);

	// Predictor copy of configuration and tables
	longint unsigned offs, stx, sty, img_w, img_h, n_sizes, n_ratios, flags;
	longint unsigned min_tab[pbg_pkg::MAX_SIZES], mean_tab[pbg_pkg::MAX_SIZES];
	longint unsigned root_tab[pbg_pkg::MAX_RATIOS], inv_tab[pbg_pkg::MAX_RATIOS];

	box_t boxes_due[$];
	box_t cell_boxes[$];
	int mismatches = 0;
	int cycles = 0;
	int idle_pct = 0;

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint unsigned root_round(longint unsigned v);
		longint unsigned rem, r, b;
		rem = v;
		r = 0;
		b = 64'd1 << 62;
		while (b > rem) b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		if (v > r * r + r) r++;
		return r;
	endfunction

	function automatic logic [pbg_pkg::OUT_W-1:0] norm_corner(longint pos,
			longint unsigned dv, bit clip);
		longint unsigned mag;
		longint q;
		mag = (pos < 0 ? -pos : pos) * 8;
		q = longint'((mag + dv / 2) / dv);
		if (pos < 0) q = -q;
		if (clip) begin
			if (q < 0) q = 0;
			if (q > 65536) q = 65536;
		end else begin
			if (q < -131072) q = -131072;
			if (q > 131071) q = 131071;
		end
		return q[pbg_pkg::OUT_W-1:0];
	endfunction

	task automatic add_box(longint cx, longint cy, longint hw, longint hh);
		box_t b;
		longint unsigned dw, dh;
		bit clip;
		dw = img_w ? img_w : 1;
		dh = img_h ? img_h : 1;
		clip = flags[pbg_pkg::FLAG_CLIP];
		b.x0 = norm_corner(cx - hw, dw, clip);
		b.y0 = norm_corner(cy - hh, dh, clip);
		b.x1 = norm_corner(cx + hw, dw, clip);
		b.y1 = norm_corner(cy + hh, dh, clip);
		b.num = 6'(cell_boxes.size());
		b.last = 1'b0;
		cell_boxes.push_back(b);
	endtask

	// Work out the effect of one accepted item
	task automatic predict_item(logic [1:0] k, logic [1:0] idx, logic [11:0] mn,
			logic [11:0] mx, logic [11:0] ra, logic [9:0] row, logic [9:0] col);
		longint unsigned rt, inv, ns, nr;
		longint cx, cy, m;
		case (k)
			pbg_pkg::KIND_SIZE: begin
				min_tab[idx] = mn;
				mean_tab[idx] = root_round(longint'(mn) * mx * 256) & 16'hFFFF;
			end
			pbg_pkg::KIND_RATIO: begin
				rt = root_round(longint'(ra) << 16);
				inv = 65535;
				if (rt != 0) begin
					inv = ((64'd1 << 24) + rt / 2) / rt;
					if (inv > 65535) inv = 65535;
				end
				root_tab[idx] = rt;
				inv_tab[idx] = inv;
			end
			pbg_pkg::KIND_CELL: begin
				ns = n_sizes > pbg_pkg::MAX_SIZES ? pbg_pkg::MAX_SIZES : n_sizes;
				nr = n_ratios > pbg_pkg::MAX_RATIOS ? pbg_pkg::MAX_RATIOS : n_ratios;
				cx = longint'((longint'(col) * 256 + offs) * stx * 2);
				cy = longint'((longint'(row) * 256 + offs) * sty * 2);
				cell_boxes.delete();
				for (int s = 0; s < ns; s++) begin
					m = min_tab[s];
					add_box(cx, cy, m << 12, m << 12);
					if (flags[pbg_pkg::FLAG_MAX])
						add_box(cx, cy, longint'(mean_tab[s]) << 8, longint'(mean_tab[s]) << 8);
					for (int r = 0; r < nr; r++) begin
						add_box(cx, cy, m * longint'(root_tab[r]), m * longint'(inv_tab[r]));
						if (flags[pbg_pkg::FLAG_FLIP])
							add_box(cx, cy, m * longint'(inv_tab[r]), m * longint'(root_tab[r]));
					end
				end
				if (cell_boxes.size() > 0) cell_boxes[$].last = 1'b1;
				foreach (cell_boxes[i]) boxes_due.push_back(cell_boxes[i]);
			end
			default: ;
		endcase
	endtask

	// Check each box beat against the oldest expectation
	always @(posedge clk) begin
		box_t e;
		if (arst_n && box_valid) begin
			if (boxes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected box beat %0d", box_number);
			end else begin
				e = boxes_due.pop_front();
				if (x_min !== e.x0 || y_min !== e.y0 || x_max !== e.x1 || y_max !== e.y1 ||
						box_number !== e.num || last_box !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("box mismatch: exp %0d %0d %0d %0d #%0d l%0b got %0d %0d %0d %0d #%0d l%0b",
							e.x0, e.y0, e.x1, e.y1, e.num, e.last,
							x_min, y_min, x_max, y_max, box_number, last_box);
				end
			end
		end
	end

	// Hold until no box is due and the block is idle
	task automatic wait_idle();
		logic b;
		while (boxes_due.size() != 0) @(posedge clk);
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Send one item; start stays high only when the next item follows at once
	task automatic send_item(logic [1:0] k, logic [1:0] idx, logic [11:0] mn,
			logic [11:0] mx, logic [11:0] ra, logic [9:0] row, logic [9:0] col);
		logic b;
		int gap;
		start <= 1'b1;
		kind <= k;
		entry_index <= idx;
		min_box <= mn;
		max_box <= mx;
		ratio <= ra;
		cell_row <= row;
		cell_col <= col;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		predict_item(k, idx, mn, mx, ra, row, col);
		gap = (int'($urandom_range(99)) < idle_pct) ? int'($urandom_range(1, 60)) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write all registers while idle
	task automatic write_regs(logic [15:0] co, logic [15:0] sx, logic [15:0] sy,
			logic [15:0] iw, logic [15:0] ih, logic [15:0] su, logic [15:0] ru,
			logic [15:0] mf);
		logic [15:0] vals[8];
		start <= 1'b0;
		wait_idle();
		vals = '{co, sx, sy, iw, ih, su, ru, mf};
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= i[pbg_pkg::CFG_IDX_W-1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			case (i[pbg_pkg::CFG_IDX_W-1:0])
				pbg_pkg::REG_CENTER_OFFSET: offs = vals[i] & 16'hFF;
				pbg_pkg::REG_STEP_X:        stx = vals[i];
				pbg_pkg::REG_STEP_Y:        sty = vals[i];
				pbg_pkg::REG_IMAGE_WIDTH:   img_w = vals[i] & 16'h1FFF;
				pbg_pkg::REG_IMAGE_HEIGHT:  img_h = vals[i] & 16'h1FFF;
				pbg_pkg::REG_SIZES_USED:    n_sizes = vals[i] & 16'h7;
				pbg_pkg::REG_RATIOS_USED:   n_ratios = vals[i] & 16'h7;
				pbg_pkg::REG_MODE_FLAGS:    flags = vals[i] & 16'h7;
			endcase
		end
		cfg_write <= 1'b0;
	endtask

	// Fill every table slot with extreme sizes and ratios, send an unused kind, then extreme cells
	task automatic test_directed();
		write_regs(0, 1, 1, 1, 1, 4, 4, 7);
		send_item(pbg_pkg::KIND_SIZE, 0, 12'd1, 12'd0, 12'd0, 0, 0);
		send_item(pbg_pkg::KIND_SIZE, 1, 12'd4095, 12'd4095, 12'd0, 0, 0);
		send_item(pbg_pkg::KIND_SIZE, 2, 12'd300, 12'd0, 12'd0, 0, 0);
		send_item(pbg_pkg::KIND_SIZE, 3, 12'd2730, 12'd1365, 12'hFFF, 10'h3FF, 10'h3FF);
		send_item(pbg_pkg::KIND_RATIO, 0, 12'd0, 12'd0, 12'd0, 0, 0);
		send_item(pbg_pkg::KIND_RATIO, 1, 12'd0, 12'd0, 12'd1, 0, 0);
		send_item(pbg_pkg::KIND_RATIO, 2, 12'hFFF, 12'hFFF, 12'd4095, 0, 0);
		send_item(pbg_pkg::KIND_RATIO, 3, 12'd0, 12'd0, 12'd512, 0, 0);
		send_item(2'd3, 3, 12'hFFF, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd0, 10'd0);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd1023, 10'd1023);
		write_regs(255, 16'hFFFF, 16'hFFFF, 4096, 4096, 4, 4, 3);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd0, 10'd1023);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd1023, 10'd0);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd5, 10'd7);
		// zero image size, oversize counts, then no sizes in use
		write_regs(128, 128, 200, 0, 0, 7, 7, 5);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd2, 10'd3);
		write_regs(16'hFFFF, 64, 64, 16'h1FFF, 300, 0, 2, 0);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd9, 10'd9);
		write_regs(128, 128, 128, 300, 300, 1, 0, 0);
		send_item(pbg_pkg::KIND_CELL, 0, 0, 0, 0, 10'd4, 10'd6);
	endtask

	// Random setting and a mix of loads, cells and unused kinds, under one sender idle rate
	task automatic test_random_phase(int pct, int n_items);
		int r;
		logic [1:0] k;
		idle_pct = pct;
		write_regs(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(8191)), 16'($urandom_range(8191)),
			16'($urandom_range(7)), 16'($urandom_range(7)), 16'($urandom_range(7)));
		for (int i = 0; i < n_items; i++) begin
			r = int'($urandom_range(99));
			if (r < 15)
				k = pbg_pkg::KIND_SIZE;
			else if (r < 30)
				k = pbg_pkg::KIND_RATIO;
			else if (r < 34)
				k = 2'd3;
			else
				k = pbg_pkg::KIND_CELL;
			send_item(k, 2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
				10'($urandom), 10'($urandom));
		end
		start <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(0, 24);
		test_random_phase(66, 24);
		test_random_phase(0, 23);
		test_random_phase(37, 23);
		start <= 1'b0;
		while (boxes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
